FILE: sv/rdpm_pkg.sv
package rdpm_pkg;

  localparam int CoordW       = 20;
  localparam int DiffW        = 21;
  localparam int SqW          = 41;
  localparam int R2W          = 42;
  localparam int CoeffW       = 32;
  localparam int UW           = 32;
  localparam int ProdW        = 64;
  localparam int MulW         = 53;
  localparam int QuotW        = 22;
  localparam int NumW         = 49;
  localparam int AccFrac      = 31;
  localparam int OutFrac      = 28;
  localparam int NumCoeffRegs = 4;
  localparam int ShiftW       = 6;
  localparam int CfgDataW     = 32;

  localparam logic signed [CoeffW-1:0] CoeffOne = 32'sh1000_0000;
  localparam logic signed [CoeffW-1:0] AccMax   = 32'sh7FFF_FFFF;
  localparam logic signed [CoeffW-1:0] AccMin   = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] OutMax   = 20'sh7_FFFF;
  localparam logic signed [CoordW-1:0] OutMin   = 20'sh8_0000;

  typedef enum logic [1:0] {
    ModeIdentity = 2'd0,
    ModePoly     = 2'd1,
    ModeDiv      = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CfgCenterX = 3'd0,
    CfgCenterY = 3'd1,
    CfgMode    = 3'd2,
    CfgShift   = 3'd3,
    CfgCoeff0  = 3'd4,
    CfgCoeff1  = 3'd5,
    CfgCoeff2  = 3'd6,
    CfgCoeff3  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] mapped_x;
    logic signed [CoordW-1:0] mapped_y;
    logic                     passed_through;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    cfg_reg_e              index;
    logic [CfgDataW-1:0]   value;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [1:0]               mode;
    logic [ShiftW-1:0]        radius_shift;
  } cfg_t;

  // Item state through the radius and Horner stages.
  typedef struct packed {
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic [UW-1:0]            u;
    logic signed [CoeffW-1:0] acc;
    logic signed [ProdW-1:0]  prod;
    logic                     sat;
  } lane_t;

  // Item state through the mapping and divider stages.
  typedef struct packed {
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [MulW-1:0]   mulx;
    logic signed [MulW-1:0]   muly;
    logic [CoeffW-1:0]        da;
    logic [NumW-1:0]          remx;
    logic [NumW-1:0]          remy;
    logic [QuotW-1:0]         qx;
    logic [QuotW-1:0]         qy;
    logic                     negx;
    logic                     negy;
    logic                     ovx;
    logic                     ovy;
    logic                     zero;
    logic                     sat;
  } div_t;

endpackage

FILE: sv/rdpm_stream_if.sv
interface rdpm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: sv/rdpm_radius.sv
module rdpm_radius (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rdpm_pkg::cfg_t                     cfg_i,
  input  logic signed [rdpm_pkg::CoeffW-1:0] coeff_top_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rdpm_pkg::point_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rdpm_pkg::lane_t                    out_data_o
);

  localparam int NumStages = 3;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] ready;

  logic signed [rdpm_pkg::DiffW-1:0] dx0_d, dy0_d, dx0_q, dy0_q, dx1_q, dy1_q;
  logic signed [rdpm_pkg::R2W-1:0]   sqx_full, sqy_full;
  logic [rdpm_pkg::SqW-1:0]          sqx1_q, sqy1_q;
  logic [rdpm_pkg::R2W-1:0]          r2, r2_shifted;
  logic                              u_sat;
  rdpm_pkg::lane_t                   lane_d, lane_q;

  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign dx0_d = {in_data_i.point_x[rdpm_pkg::CoordW-1], in_data_i.point_x}
               - {cfg_i.center_x[rdpm_pkg::CoordW-1], cfg_i.center_x};
  assign dy0_d = {in_data_i.point_y[rdpm_pkg::CoordW-1], in_data_i.point_y}
               - {cfg_i.center_y[rdpm_pkg::CoordW-1], cfg_i.center_y};

  assign sqx_full = rdpm_pkg::R2W'(dx0_q) * rdpm_pkg::R2W'(dx0_q);
  assign sqy_full = rdpm_pkg::R2W'(dy0_q) * rdpm_pkg::R2W'(dy0_q);

  // Shifts of 42 or more leave zero, as the shifter does on its own.
  assign r2         = {1'b0, sqx1_q} + {1'b0, sqy1_q};
  assign r2_shifted = r2 >> cfg_i.radius_shift;
  assign u_sat      = |r2_shifted[rdpm_pkg::R2W-1:rdpm_pkg::UW];

  always_comb begin
    lane_d      = '0;
    lane_d.dx   = dx1_q;
    lane_d.dy   = dy1_q;
    lane_d.u    = u_sat ? '1 : r2_shifted[rdpm_pkg::UW-1:0];
    lane_d.acc  = coeff_top_i;
    lane_d.sat  = u_sat;
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      dx0_q <= dx0_d;
      dy0_q <= dy0_d;
    end
    if (ready[1]) begin
      dx1_q  <= dx0_q;
      dy1_q  <= dy0_q;
      sqx1_q <= sqx_full[rdpm_pkg::SqW-1:0];
      sqy1_q <= sqy_full[rdpm_pkg::SqW-1:0];
    end
    if (ready[2]) begin
      lane_q <= lane_d;
    end
  end

endmodule

FILE: sv/rdpm_horner_step.sv
module rdpm_horner_step (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [rdpm_pkg::CoeffW-1:0] coeff_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rdpm_pkg::lane_t                    in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rdpm_pkg::lane_t                    out_data_o
);

  localparam int NumStages = 2;
  localparam int SumW      = rdpm_pkg::ProdW - rdpm_pkg::AccFrac + 1;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] ready;

  logic signed [rdpm_pkg::ProdW-1:0] prod_d;
  logic signed [SumW-1:0]            sum;
  logic                              ovf;
  rdpm_pkg::lane_t                   mul_d, mul_q, acc_d, acc_q;

  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    ready[0]           = !valid_q[0] || ready[1];
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      if (ready[1]) valid_q[1] <= valid_q[0];
    end
  end

  // u is unsigned, so it enters the signed product with a zero on top.
  assign prod_d = rdpm_pkg::ProdW'(in_data_i.acc)
                * rdpm_pkg::ProdW'($signed({1'b0, in_data_i.u}));

  always_comb begin
    mul_d      = in_data_i;
    mul_d.prod = prod_d;
  end

  // The arithmetic shift of the product gives the floor of the scaled value.
  assign sum = SumW'($signed(mul_q.prod[rdpm_pkg::ProdW-1:rdpm_pkg::AccFrac]))
             + SumW'(coeff_i);
  assign ovf = (sum[SumW-1:rdpm_pkg::CoeffW-1] != '0)
            && (sum[SumW-1:rdpm_pkg::CoeffW-1] != '1);

  always_comb begin
    acc_d     = mul_q;
    acc_d.sat = mul_q.sat || ovf;
    if (ovf) begin
      acc_d.acc = sum[SumW-1] ? rdpm_pkg::AccMin : rdpm_pkg::AccMax;
    end else begin
      acc_d.acc = sum[rdpm_pkg::CoeffW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) mul_q <= mul_d;
    if (ready[1]) acc_q <= acc_d;
  end

endmodule

FILE: sv/rdpm_map.sv
module rdpm_map (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rdpm_pkg::lane_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rdpm_pkg::div_t  out_data_o
);

  localparam int NumStages = 1 + rdpm_pkg::QuotW;
  localparam int CmpW      = rdpm_pkg::CoeffW + rdpm_pkg::QuotW;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] ready;

  rdpm_pkg::div_t stage_d [NumStages];
  rdpm_pkg::div_t stage_q [NumStages];

  logic [rdpm_pkg::DiffW-1:0]  absx, absy;
  logic [rdpm_pkg::NumW-1:0]   numx, numy;
  logic [rdpm_pkg::CoeffW-1:0] da;
  logic [CmpW-1:0]             da_top;

  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = stage_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Division runs on magnitudes; the quotient sign is applied at the end,
  // which rounds toward zero.
  assign absx   = in_data_i.dx[rdpm_pkg::DiffW-1] ? -in_data_i.dx : in_data_i.dx;
  assign absy   = in_data_i.dy[rdpm_pkg::DiffW-1] ? -in_data_i.dy : in_data_i.dy;
  assign numx   = {absx, rdpm_pkg::OutFrac'(0)};
  assign numy   = {absy, rdpm_pkg::OutFrac'(0)};
  assign da     = in_data_i.acc[rdpm_pkg::CoeffW-1] ? -in_data_i.acc : in_data_i.acc;
  assign da_top = {da, rdpm_pkg::QuotW'(0)};

  always_comb begin
    stage_d[0]      = '0;
    stage_d[0].dx   = in_data_i.dx;
    stage_d[0].dy   = in_data_i.dy;
    stage_d[0].mulx = rdpm_pkg::MulW'(in_data_i.dx) * rdpm_pkg::MulW'(in_data_i.acc);
    stage_d[0].muly = rdpm_pkg::MulW'(in_data_i.dy) * rdpm_pkg::MulW'(in_data_i.acc);
    stage_d[0].da   = da;
    stage_d[0].remx = numx;
    stage_d[0].remy = numy;
    stage_d[0].negx = in_data_i.dx[rdpm_pkg::DiffW-1] ^ in_data_i.acc[rdpm_pkg::CoeffW-1];
    stage_d[0].negy = in_data_i.dy[rdpm_pkg::DiffW-1] ^ in_data_i.acc[rdpm_pkg::CoeffW-1];
    // A quotient that does not fit in the quotient width clamps at the output.
    stage_d[0].ovx  = CmpW'(numx) >= da_top;
    stage_d[0].ovy  = CmpW'(numy) >= da_top;
    stage_d[0].zero = (in_data_i.acc == '0);
    stage_d[0].sat  = in_data_i.sat;
  end

  for (genvar k = 1; k < NumStages; k++) begin : g_div
    localparam int Bit = rdpm_pkg::QuotW - k;
    logic [CmpW-1:0] dsh;

    assign dsh = CmpW'(stage_q[k-1].da) << Bit;

    always_comb begin
      stage_d[k] = stage_q[k-1];
      if (!stage_q[k-1].ovx && (CmpW'(stage_q[k-1].remx) >= dsh)) begin
        stage_d[k].remx    = stage_q[k-1].remx - dsh[rdpm_pkg::NumW-1:0];
        stage_d[k].qx[Bit] = 1'b1;
      end
      if (!stage_q[k-1].ovy && (CmpW'(stage_q[k-1].remy) >= dsh)) begin
        stage_d[k].remy    = stage_q[k-1].remy - dsh[rdpm_pkg::NumW-1:0];
        stage_d[k].qy[Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (ready[k]) stage_q[k] <= stage_d[k];
    end
  end

endmodule

FILE: sv/radial_distortion_point_map_unit.sv
// Pipeline from an accepted point to its result: three radius stages, two
// stages per each of the NUM_COEFFS - 1 Horner steps, one mapping stage, one
// restoring divider stage per quotient bit, and the output register. Throughput
// is one item per cycle while the result output is not stalled; every stage has
// its own valid bit, so a stall only holds stages that are full. Reset clears all
// valid bits and returns the configuration and coefficient registers to their defaults.
module radial_distortion_point_map_unit #(
  parameter int NUM_COEFFS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rdpm_stream_if.sink   point_i,
  rdpm_stream_if.source result_o,
  rdpm_stream_if.sink   cfg_i
);

  localparam int SumW = 26;

  rdpm_pkg::cfg_t                     cfg_q;
  logic signed [rdpm_pkg::CoeffW-1:0] coeff_q [rdpm_pkg::NumCoeffRegs];
  logic signed [rdpm_pkg::CoeffW-1:0] coeff_w [NUM_COEFFS];

  rdpm_pkg::lane_t h_data  [NUM_COEFFS];
  logic            h_valid [NUM_COEFFS];
  logic            h_ready [NUM_COEFFS];

  logic           map_valid, map_ready;
  rdpm_pkg::div_t map_data;

  logic             out_valid_q;
  rdpm_pkg::result_t out_d, out_q;

  logic signed [rdpm_pkg::DiffW-1:0] pass_x, pass_y;
  logic signed [SumW-1:0]            poly_x, poly_y, div_x, div_y;
  logic [rdpm_pkg::QuotW-1:0]        qmag_x, qmag_y;
  logic signed [rdpm_pkg::QuotW:0]   qs_x, qs_y;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      for (int j = 0; j < rdpm_pkg::NumCoeffRegs; j++) begin
        coeff_q[j] <= '0;
      end
      coeff_q[0] <= rdpm_pkg::CoeffOne;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        rdpm_pkg::CfgCenterX: cfg_q.center_x <= cfg_i.data.value[rdpm_pkg::CoordW-1:0];
        rdpm_pkg::CfgCenterY: cfg_q.center_y <= cfg_i.data.value[rdpm_pkg::CoordW-1:0];
        rdpm_pkg::CfgMode:    cfg_q.mode     <= cfg_i.data.value[1:0];
        rdpm_pkg::CfgShift:   cfg_q.radius_shift <= cfg_i.data.value[rdpm_pkg::ShiftW-1:0];
        rdpm_pkg::CfgCoeff0:  coeff_q[0] <= cfg_i.data.value;
        rdpm_pkg::CfgCoeff1:  coeff_q[1] <= cfg_i.data.value;
        rdpm_pkg::CfgCoeff2:  coeff_q[2] <= cfg_i.data.value;
        rdpm_pkg::CfgCoeff3:  coeff_q[3] <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // Coefficients beyond the register set are zero.
  for (genvar j = 0; j < NUM_COEFFS; j++) begin : g_coeff
    if (j < rdpm_pkg::NumCoeffRegs) begin : g_reg
      assign coeff_w[j] = coeff_q[j];
    end else begin : g_zero
      assign coeff_w[j] = '0;
    end
  end

  rdpm_radius u_radius (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .coeff_top_i (coeff_w[NUM_COEFFS-1]),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (point_i.ready),
    .in_data_i   (point_i.data),
    .out_valid_o (h_valid[0]),
    .out_ready_i (h_ready[0]),
    .out_data_o  (h_data[0])
  );

  for (genvar s = 0; s < NUM_COEFFS - 1; s++) begin : g_horner
    localparam int Idx = NUM_COEFFS - 2 - s;
    rdpm_horner_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .coeff_i     (coeff_w[Idx]),
      .in_valid_i  (h_valid[s]),
      .in_ready_o  (h_ready[s]),
      .in_data_i   (h_data[s]),
      .out_valid_o (h_valid[s+1]),
      .out_ready_i (h_ready[s+1]),
      .out_data_o  (h_data[s+1])
    );
  end

  rdpm_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (h_valid[NUM_COEFFS-1]),
    .in_ready_o  (h_ready[NUM_COEFFS-1]),
    .in_data_i   (h_data[NUM_COEFFS-1]),
    .out_valid_o (map_valid),
    .out_ready_i (map_ready),
    .out_data_o  (map_data)
  );

  function automatic logic in_range(logic signed [SumW-1:0] v);
    return (v[SumW-1:rdpm_pkg::CoordW-1] == '0) || (v[SumW-1:rdpm_pkg::CoordW-1] == '1);
  endfunction

  function automatic logic signed [rdpm_pkg::CoordW-1:0] clamp_coord(
    logic signed [SumW-1:0] v
  );
    if (in_range(v)) return v[rdpm_pkg::CoordW-1:0];
    return v[SumW-1] ? rdpm_pkg::OutMin : rdpm_pkg::OutMax;
  endfunction

  // The original point is rebuilt from its offset.
  assign pass_x = map_data.dx + rdpm_pkg::DiffW'(cfg_q.center_x);
  assign pass_y = map_data.dy + rdpm_pkg::DiffW'(cfg_q.center_y);

  assign poly_x = SumW'($signed(map_data.mulx[rdpm_pkg::MulW-1:rdpm_pkg::OutFrac]))
                + SumW'(cfg_q.center_x);
  assign poly_y = SumW'($signed(map_data.muly[rdpm_pkg::MulW-1:rdpm_pkg::OutFrac]))
                + SumW'(cfg_q.center_y);

  assign qmag_x = map_data.ovx ? '1 : map_data.qx;
  assign qmag_y = map_data.ovy ? '1 : map_data.qy;
  assign qs_x   = map_data.negx ? -$signed({1'b0, qmag_x}) : $signed({1'b0, qmag_x});
  assign qs_y   = map_data.negy ? -$signed({1'b0, qmag_y}) : $signed({1'b0, qmag_y});
  assign div_x  = SumW'(qs_x) + SumW'(cfg_q.center_x);
  assign div_y  = SumW'(qs_y) + SumW'(cfg_q.center_y);

  always_comb begin
    out_d.mapped_x       = pass_x[rdpm_pkg::CoordW-1:0];
    out_d.mapped_y       = pass_y[rdpm_pkg::CoordW-1:0];
    out_d.passed_through = 1'b1;
    out_d.saturated      = 1'b0;
    case (cfg_q.mode)
      rdpm_pkg::ModePoly: begin
        out_d.mapped_x       = clamp_coord(poly_x);
        out_d.mapped_y       = clamp_coord(poly_y);
        out_d.passed_through = 1'b0;
        out_d.saturated      = map_data.sat || !in_range(poly_x) || !in_range(poly_y);
      end
      rdpm_pkg::ModeDiv: begin
        if (map_data.zero) begin
          out_d.saturated = map_data.sat;
        end else begin
          out_d.mapped_x       = clamp_coord(div_x);
          out_d.mapped_y       = clamp_coord(div_y);
          out_d.passed_through = 1'b0;
          out_d.saturated      = map_data.sat || !in_range(div_x) || !in_range(div_y);
        end
      end
      default: ;
    endcase
  end

  assign map_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (map_ready) begin
      out_valid_q <= map_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_ready) out_q <= out_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule
